/* src/mtr_pkg.sv */
package mtr_pkg;

    localparam int MAX_EXPERTS_DEF = 256;
    localparam int MAX_TOPK_DEF    = 8;

    localparam int LOGIT_W    = 16;
    localparam int SCORE_W    = 17;
    localparam int SCALE_W    = 16;
    localparam int TOPK_W     = 4;
    localparam int ID_W       = 9;
    localparam int WEIGHT_W   = 32;
    localparam int PROD_W     = 33;
    localparam int DIVD_W     = 42;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    localparam logic [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TOP_K        = 2'd0,
        REG_NEED_NORM    = 2'd1,
        REG_ROUTE_SCALE  = 2'd2,
        REG_SHARED_SCALE = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_SUM,
        ST_MUL,
        ST_CALC,
        ST_DIV,
        ST_OUT,
        ST_SHARED
    } state_t;

    typedef struct packed {
        logic accept;
        logic last;
        logic sum_add;
        logic j_inc;
        logic j_clr;
        logic load_prod;
        logic div_start;
        logic load_res;
        logic load_shared;
        logic list_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic j_last;
        logic use_div;
        logic div_done;
    } dp_sts_t;

endpackage

/* src/moe_topk_expert_router.sv */
// Top-k expert router: takes one expert's gate logit and bias per cycle while
// collecting a token, inserting it into a sorted list of up to MAX_TOPK entries
// in the cycle it is accepted. On the last expert the intake closes while
// results are produced: the n chosen logits are summed (skipped when the list is
// empty), then each routed result takes a multiply step and a calc step (plus
// the bit-serial divider when normalising by a non-zero sum) and the output
// handshake, then one shared-expert result follows.
// Intake reopens the cycle after the shared result is taken.
module moe_topk_expert_router #(
    parameter int MAX_EXPERTS = mtr_pkg::MAX_EXPERTS_DEF,
    parameter int MAX_TOPK    = mtr_pkg::MAX_TOPK_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mtr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mtr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mtr_pkg::IN_DATA_W-1:0]     s_tdata,   // logit, gate_bias
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mtr_pkg::OUT_DATA_W-1:0]    m_tdata,   // expert_id, weight, pad
    output logic                              m_tlast
);

    mtr_pkg::dp_cmd_t                    cmd;
    mtr_pkg::dp_sts_t                    sts;
    logic [mtr_pkg::ID_W-1:0]            expert_id;
    logic signed [mtr_pkg::WEIGHT_W-1:0] weight;

    mtr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    mtr_dp #(
        .MAX_EXPERTS (MAX_EXPERTS),
        .MAX_TOPK    (MAX_TOPK)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .logit       (s_tdata[15:0]),
        .gate_bias   (s_tdata[31:16]),
        .cmd         (cmd),
        .sts         (sts),
        .expert_id   (expert_id),
        .weight      (weight),
        .last_result (m_tlast)
    );

    assign m_tdata = {7'b0, weight, expert_id};

endmodule

/* src/mtr_div.sv */
module mtr_div #(
    parameter int DIVD_W = mtr_pkg::DIVD_W,
    parameter int DVS_W  = 21
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/mtr_dp.sv */
module mtr_dp #(
    parameter int MAX_EXPERTS = mtr_pkg::MAX_EXPERTS_DEF,
    parameter int MAX_TOPK    = mtr_pkg::MAX_TOPK_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mtr_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mtr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [mtr_pkg::LOGIT_W-1:0]  logit,
    input  logic signed [mtr_pkg::LOGIT_W-1:0]  gate_bias,
    input  mtr_pkg::dp_cmd_t                    cmd,
    output mtr_pkg::dp_sts_t                    sts,
    output logic [mtr_pkg::ID_W-1:0]            expert_id,
    output logic signed [mtr_pkg::WEIGHT_W-1:0] weight,
    output logic                                last_result
);

    localparam int IDX_W = $clog2(MAX_EXPERTS);
    localparam int CNT_W = $clog2(MAX_TOPK + 1);
    localparam int POS_W = (MAX_TOPK > 1) ? $clog2(MAX_TOPK) : 1;
    localparam int SUM_W = mtr_pkg::SCORE_W + $clog2(MAX_TOPK);
    localparam int DVS_W = SUM_W + 1;
    localparam int LW    = mtr_pkg::LOGIT_W;
    localparam int WW    = mtr_pkg::WEIGHT_W;
    localparam int PW    = mtr_pkg::PROD_W;
    localparam int DW    = mtr_pkg::DIVD_W;

    localparam logic [WW-1:0] W_MAX_L = mtr_pkg::W_MAX;
    localparam logic [WW-1:0] W_MIN_L = mtr_pkg::W_MIN;

    logic [mtr_pkg::TOPK_W-1:0]  top_k_reg;
    logic                        need_norm_reg;
    logic [mtr_pkg::SCALE_W-1:0] route_scale_reg;
    logic [mtr_pkg::SCALE_W-1:0] shared_scale_reg;

    logic signed [mtr_pkg::SCORE_W-1:0] best_score_reg [MAX_TOPK];
    logic signed [LW-1:0]               best_logit_reg [MAX_TOPK];
    logic [IDX_W-1:0]                   best_index_reg [MAX_TOPK];
    logic [CNT_W-1:0]                   filled_reg, filled_next;
    logic [IDX_W-1:0]                   counter_reg, counter_next;
    logic [POS_W-1:0]                   j_reg;
    logic signed [SUM_W-1:0]            acc_reg;
    logic signed [PW-1:0]               prod_reg;
    logic [mtr_pkg::ID_W-1:0]           out_id_reg;
    logic [WW-1:0]                      out_w_reg;
    logic                               out_last_reg;

    logic [CNT_W-1:0]                   cap, n, p, top;
    logic signed [mtr_pkg::SCORE_W-1:0] score_in;
    logic                               do_ins;
    logic signed [PW-1:0]               prod_c;
    logic                               prod_neg, sum_neg, q_neg;
    logic [WW-1:0]                      prod_mag;
    logic [SUM_W-1:0]                   sum_mag;
    logic [DW-1:0]                      dividend;
    logic [DW-1:0]                      quo;
    logic                               div_done;
    logic [WW:0]                        dq_full;
    logic [WW-1:0]                      dq, w_direct, w_zero, w_div, w_sel;
    logic [mtr_pkg::ID_W+IDX_W-1:0]     id_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_k_reg        <= mtr_pkg::TOPK_W'(1);
            need_norm_reg    <= 1'b0;
            route_scale_reg  <= mtr_pkg::SCALE_W'(256);
            shared_scale_reg <= mtr_pkg::SCALE_W'(256);
        end
        else if (cfg_we)
        begin
            unique case (mtr_pkg::cfg_reg_t'(cfg_addr))
                mtr_pkg::REG_TOP_K:        top_k_reg        <= cfg_data[mtr_pkg::TOPK_W-1:0];
                mtr_pkg::REG_NEED_NORM:    need_norm_reg    <= cfg_data[0];
                mtr_pkg::REG_ROUTE_SCALE:  route_scale_reg  <= cfg_data;
                mtr_pkg::REG_SHARED_SCALE: shared_scale_reg <= cfg_data;
                default:                   need_norm_reg    <= need_norm_reg;
            endcase
        end
    end

    always_comb
    begin
        cap      = (32'(top_k_reg) > MAX_TOPK) ? CNT_W'(MAX_TOPK) : CNT_W'(top_k_reg);
        n        = (filled_reg < cap) ? filled_reg : cap;
        top      = (n < cap) ? n : cap - 1'b1;
        score_in = mtr_pkg::SCORE_W'(logit) + mtr_pkg::SCORE_W'(gate_bias);
        p        = '0;
        for (int i = 0; i < MAX_TOPK; i++)
        begin
            if ((CNT_W'(i) < n) && (best_score_reg[i] >= score_in))
            begin
                p = p + 1'b1;
            end
        end
        do_ins = cmd.accept && (p < cap);
    end

    always_ff @(posedge clk)
    begin
        if (do_ins)
        begin
            for (int i = 0; i < MAX_TOPK; i++)
            begin
                if (CNT_W'(i) == p)
                begin
                    best_score_reg[i] <= score_in;
                    best_logit_reg[i] <= logit;
                    best_index_reg[i] <= counter_reg;
                end
                else if ((CNT_W'(i) > p) && (CNT_W'(i) <= top) && (i > 0))
                begin
                    best_score_reg[i] <= best_score_reg[(i > 0) ? i - 1 : 0];
                    best_logit_reg[i] <= best_logit_reg[(i > 0) ? i - 1 : 0];
                    best_index_reg[i] <= best_index_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    always_comb
    begin
        filled_next = filled_reg;
        if (cmd.list_clr)
        begin
            filled_next = '0;
        end
        else if (do_ins)
        begin
            filled_next = (n < cap) ? n + 1'b1 : cap;
        end
        counter_next = counter_reg;
        if (cmd.accept)
        begin
            if (cmd.last || (32'(counter_reg) + 1 >= MAX_EXPERTS))
            begin
                counter_next = '0;
            end
            else
            begin
                counter_next = counter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg  <= '0;
            counter_reg <= '0;
            j_reg       <= '0;
        end
        else
        begin
            filled_reg  <= filled_next;
            counter_reg <= counter_next;
            if (cmd.j_clr)
            begin
                j_reg <= '0;
            end
            else if (cmd.j_inc)
            begin
                j_reg <= j_reg + 1'b1;
            end
        end
    end

    assign prod_c = PW'(best_logit_reg[j_reg]) * $signed({1'b0, route_scale_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.last)
        begin
            acc_reg <= '0;
        end
        else if (cmd.sum_add)
        begin
            acc_reg <= acc_reg + SUM_W'(best_logit_reg[j_reg]);
        end
        if (cmd.load_prod)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.load_res)
        begin
            out_id_reg   <= id_full[mtr_pkg::ID_W-1:0];
            out_w_reg    <= w_sel;
            out_last_reg <= 1'b0;
        end
        else if (cmd.load_shared)
        begin
            out_id_reg   <= '0;
            out_w_reg    <= WW'({shared_scale_reg, 8'h00});
            out_last_reg <= 1'b1;
        end
    end

    always_comb
    begin
        prod_neg = prod_reg[PW-1];
        prod_mag = prod_neg ? WW'(-prod_reg) : WW'(prod_reg);
        sum_neg  = acc_reg[SUM_W-1];
        sum_mag  = sum_neg ? SUM_W'(-acc_reg) : SUM_W'(acc_reg);
        q_neg    = prod_neg ^ sum_neg;
        dividend = DW'({prod_mag, 9'b0}) + DW'(sum_mag);
        dq_full  = ({1'b0, prod_mag} + (WW + 1)'(8)) >> 4;
        dq       = dq_full[WW-1:0];
        w_direct = prod_neg ? WW'(-dq) : dq;
        w_zero   = prod_neg ? W_MIN_L : ((prod_mag != '0) ? W_MAX_L : '0);
        if (!q_neg)
        begin
            w_div = (quo > DW'(mtr_pkg::W_MAX)) ? mtr_pkg::W_MAX : quo[WW-1:0];
        end
        else
        begin
            w_div = (quo > DW'(mtr_pkg::W_MIN)) ? mtr_pkg::W_MIN : WW'(-quo[WW-1:0]);
        end
        priority if (!need_norm_reg)
        begin
            w_sel = w_direct;
        end
        else if (acc_reg == '0)
        begin
            w_sel = w_zero;
        end
        else
        begin
            w_sel = w_div;
        end
        id_full = (mtr_pkg::ID_W + IDX_W)'(best_index_reg[j_reg]) + 1'b1;
    end

    mtr_div #(
        .DIVD_W (DW),
        .DVS_W  (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  ({sum_mag, 1'b0}),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        sts.n_zero   = (n == '0);
        sts.j_last   = (CNT_W'(j_reg) == n - 1'b1);
        sts.use_div  = need_norm_reg && (acc_reg != '0);
        sts.div_done = div_done;
    end

    assign expert_id   = out_id_reg;
    assign weight      = out_w_reg;
    assign last_result = out_last_reg;

endmodule

/* src/mtr_ctrl.sv */
module mtr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    input  logic             m_tready,
    input  mtr_pkg::dp_sts_t sts,
    output logic             s_tready,
    output logic             m_tvalid,
    output mtr_pkg::dp_cmd_t cmd
);

    mtr_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtr_pkg::ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mtr_pkg::ST_COLLECT:
                if (s_tvalid && s_tlast)
                begin
                    state_next = mtr_pkg::ST_SUM;
                end
            mtr_pkg::ST_SUM:
                if (sts.n_zero)
                begin
                    state_next = mtr_pkg::ST_SHARED;
                end
                else if (sts.j_last)
                begin
                    state_next = mtr_pkg::ST_MUL;
                end
            mtr_pkg::ST_MUL:
                state_next = mtr_pkg::ST_CALC;
            mtr_pkg::ST_CALC:
                state_next = sts.use_div ? mtr_pkg::ST_DIV : mtr_pkg::ST_OUT;
            mtr_pkg::ST_DIV:
                if (sts.div_done)
                begin
                    state_next = mtr_pkg::ST_OUT;
                end
            mtr_pkg::ST_OUT:
                if (m_tready)
                begin
                    state_next = sts.j_last ? mtr_pkg::ST_SHARED : mtr_pkg::ST_MUL;
                end
            mtr_pkg::ST_SHARED:
                if (m_tready)
                begin
                    state_next = mtr_pkg::ST_COLLECT;
                end
            default:
                state_next = mtr_pkg::ST_COLLECT;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            mtr_pkg::ST_COLLECT:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                cmd.last   = s_tvalid && s_tlast;
                cmd.j_clr  = s_tvalid && s_tlast;
            end
            mtr_pkg::ST_SUM:
            begin
                if (sts.n_zero)
                begin
                    cmd.load_shared = 1'b1;
                end
                else
                begin
                    cmd.sum_add = 1'b1;
                    cmd.j_clr   = sts.j_last;
                    cmd.j_inc   = !sts.j_last;
                end
            end
            mtr_pkg::ST_MUL:
                cmd.load_prod = 1'b1;
            mtr_pkg::ST_CALC:
            begin
                cmd.div_start = sts.use_div;
                cmd.load_res  = !sts.use_div;
            end
            mtr_pkg::ST_DIV:
                cmd.load_res = sts.div_done;
            mtr_pkg::ST_OUT:
            begin
                m_tvalid        = 1'b1;
                cmd.load_shared = m_tready && sts.j_last;
                cmd.j_inc       = m_tready && !sts.j_last;
            end
            mtr_pkg::ST_SHARED:
            begin
                m_tvalid     = 1'b1;
                cmd.list_clr = m_tready;
            end
            default:
                cmd = '0;
        endcase
    end

    a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output both open");

    a_div_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == mtr_pkg::ST_DIV))
        else $error("divider started outside divide step");

    a_shared_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mtr_pkg::ST_SHARED && m_tready) |=> s_tready)
        else $error("not ready after shared result");

    a_res_needs_list: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_res |-> !sts.n_zero)
        else $error("result loaded from empty list");

endmodule

/* sim/tb.sv */
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] logit;
        logic signed [15:0] bias;
        logic               last;
    } gate_req_t;

    typedef struct {
        logic [mtr_pkg::ID_W-1:0]     id;
        logic [mtr_pkg::WEIGHT_W-1:0] weight;
        logic                         last;
    } route_res_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [mtr_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [mtr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mtr_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                           s_tlast = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mtr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;

    gate_req_t  req_q[$];
    route_res_t route_q[$];
    gate_req_t  cur_req;

    logic [3:0]  k_reg = 4'd1;
    logic        norm_reg = 1'b0;
    logic [15:0] rscale_reg = 16'd256;
    logic [15:0] sscale_reg = 16'd256;

    int          sel_score[mtr_pkg::MAX_TOPK_DEF];
    int          sel_logit[mtr_pkg::MAX_TOPK_DEF];
    int          sel_index[mtr_pkg::MAX_TOPK_DEF];
    int          sel_fill = 0;
    int          exp_count = 0;

    int          errors = 0;
    int          reqs_sent = 0;
    int          results_seen = 0;
    int          tokens_done = 0;
    int          cycles = 0;
    bit          idle_en = 1'b1;
    bit          hold_go = 1'b0;
    bit          hold_done = 1'b0;
    int          stall_left = 0;

    moe_topk_expert_router dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint clip_w(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic route_token_step(gate_req_t r);
        int         lg;
        int         score;
        int         cap;
        int         n;
        int         p;
        int         top;
        longint     sum;
        longint     prod;
        longint     w;
        longint     num;
        longint     den;
        route_res_t res;
        lg = r.logit;
        score = lg + int'(r.bias);
        cap = (k_reg > mtr_pkg::MAX_TOPK_DEF) ? mtr_pkg::MAX_TOPK_DEF : k_reg;
        n = (sel_fill < cap) ? sel_fill : cap;
        p = 0;
        while (p < n && sel_score[p] >= score)
            p++;
        if (p < cap)
        begin
            top = (n < cap) ? n : cap - 1;
            for (int i = top; i > p; i--)
            begin
                sel_score[i] = sel_score[i-1];
                sel_logit[i] = sel_logit[i-1];
                sel_index[i] = sel_index[i-1];
            end
            sel_score[p] = score;
            sel_logit[p] = lg;
            sel_index[p] = exp_count;
            sel_fill = (n < cap) ? n + 1 : cap;
        end
        exp_count = (exp_count + 1 >= mtr_pkg::MAX_EXPERTS_DEF) ? 0 : exp_count + 1;
        if (!r.last)
            return;
        n = (sel_fill < cap) ? sel_fill : cap;
        sum = 0;
        for (int i = 0; i < n; i++)
            sum += sel_logit[i];
        for (int i = 0; i < n; i++)
        begin
            prod = longint'(sel_logit[i]) * longint'(rscale_reg);
            if (!norm_reg)
                w = round_div(prod, 16);
            else if (sum == 0)
                w = (prod > 0) ? 64'sd2147483647 : ((prod < 0) ? -64'sd2147483648 : 0);
            else
            begin
                num = prod * 256;
                den = sum;
                if (den < 0)
                begin
                    den = -den;
                    num = -num;
                end
                w = round_div(num, den);
            end
            w = clip_w(w);
            res.id = mtr_pkg::ID_W'(sel_index[i] + 1);
            res.weight = w[31:0];
            res.last = 1'b0;
            route_q = {route_q, res};
        end
        res.id = '0;
        res.weight = {8'd0, sscale_reg, 8'd0};
        res.last = 1'b1;
        route_q = {route_q, res};
        sel_fill = 0;
        exp_count = 0;
        tokens_done++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                route_token_step(cur_req);
                reqs_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (req_q.size() > 0 && !(idle_en && $urandom_range(99) < 33))
                begin
                    cur_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.bias, cur_req.logit};
                    s_tlast <= cur_req.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (!hold_done && hold_go)
            begin
                hold_done = 1'b1;
                stall_left = 400;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !(idle_en && $urandom_range(99) < 33);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        route_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (route_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result id=%0d weight=%h last=%b", $time,
                         m_tdata[8:0], m_tdata[40:9], m_tlast);
            end
            else
            begin
                e = route_q.pop_front();
                if (m_tdata[8:0] !== e.id)
                begin
                    errors++;
                    $display("%0t: expert_id expected %0d actual %0d", $time, e.id, m_tdata[8:0]);
                end
                if (m_tdata[40:9] !== e.weight)
                begin
                    errors++;
                    $display("%0t: weight expected %h actual %h", $time, e.weight,
                             m_tdata[40:9]);
                end
                if (m_tlast !== e.last)
                begin
                    errors++;
                    $display("%0t: last_result expected %b actual %b", $time, e.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_req(int lg, int b, bit last);
        gate_req_t r;
        r.logit = lg[15:0];
        r.bias = b[15:0];
        r.last = last;
        req_q = {req_q, r};
    endtask

    task automatic add_token(int len);
        int lg;
        int b;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(3))
                0: lg = $urandom_range(7) * 512 - 2048;
                1: lg = $urandom_range(200) - 100;
                default: lg = $urandom_range(65535) - 32768;
            endcase
            b = ($urandom_range(2) == 0) ? 0 : $urandom_range(65535) - 32768;
            add_req(lg, b, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (req_q.size() > 0 || s_tvalid || route_q.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(mtr_pkg::cfg_reg_t a, int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= a;
        cfg_data <= v[15:0];
        case (a)
            mtr_pkg::REG_TOP_K:       k_reg = v[3:0];
            mtr_pkg::REG_NEED_NORM:   norm_reg = v[0];
            mtr_pkg::REG_ROUTE_SCALE: rscale_reg = v[15:0];
            default:                  sscale_reg = v[15:0];
        endcase
    endtask

    task automatic set_config(int k, int nrm, int rs, int ss);
        wait_drained();
        write_reg(mtr_pkg::REG_TOP_K, k);
        write_reg(mtr_pkg::REG_NEED_NORM, nrm);
        write_reg(mtr_pkg::REG_ROUTE_SCALE, rs);
        write_reg(mtr_pkg::REG_SHARED_SCALE, ss);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        add_req(1000, 0, 1'b0);
        add_req(2000, -1500, 1'b1);

        set_config(2, 1, 256, 0);
        add_req(4096, 0, 1'b0);
        add_req(-4096, 0, 1'b1);
        add_req(0, 0, 1'b0);
        add_req(0, 0, 1'b1);
        add_req(32767, -32768, 1'b0);
        add_req(-32768, 32767, 1'b0);
        add_req(-32768, -32768, 1'b1);

        set_config(8, 0, 65535, 65535);
        add_req(32767, 32767, 1'b0);
        add_req(-32768, 0, 1'b0);
        add_req(100, 0, 1'b0);
        add_req(100, 0, 1'b0);
        add_req(50, 50, 1'b1);

        set_config(15, 1, 65535, 1);
        add_req(-32768, 0, 1'b0);
        add_req(-32768, 0, 1'b0);
        add_req(-1, 0, 1'b1);

        set_config(0, 0, 0, 65535);
        add_req(1234, 0, 1'b0);
        add_req(-5, 0, 1'b1);

        // top_k narrowed in the middle of a token
        set_config(8, 1, 300, 128);
        add_req(3000, 0, 1'b0);
        add_req(2000, 0, 1'b0);
        add_req(1000, 0, 1'b0);
        set_config(2, 1, 300, 128);
        add_req(2500, 0, 1'b1);

        for (int ph = 0; ph < 7; ph++)
        begin
            k = (ph == 0) ? 8 : (ph == 1) ? 1 : (ph == 2) ? 15 : $urandom_range(15);
            set_config(k, $urandom_range(1),
                       (ph == 3) ? 65535 : (ph == 4) ? 0 : $urandom_range(65535),
                       (ph == 5) ? 0 : $urandom_range(65535));
            idle_en = (ph != 2);
            if (ph == 3)
                hold_go = 1'b1;
            if (ph == 1)
                add_token(258);
            while (req_q.size() < ((ph == 2) ? 25 : 10))
                add_token($urandom_range(1, 12));
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (route_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, route_q.size());
        end
        $display("Covered %0d expert requests over %0d tokens, %0d results checked,",
                 reqs_sent, tokens_done, results_seen);
        $display("with top_k 0 to 15, normalisation on and off and extreme scales.");
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
